// ===== sv/chull_pkg.sv =====
// ----------------------------------------------------------------------------
// chull_pkg: shared constants and helpers of the convex hull block
// Sizes of the point store, coordinate and product widths, difference helpers.
// ----------------------------------------------------------------------------
package chull_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int NORM_W = DIFF_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int PT_W   = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [NORM_W-1:0]     norm_t;

  // exact difference of two coordinates, one bit wider
  function automatic diff_t coord_diff(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'(a);
    eb = diff_t'(b);
    return ea - eb;
  endfunction

  function automatic norm_t diff_mag(diff_t d);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? (~d + 1'b1) : d;
    return {1'b0, m};
  endfunction

endpackage

// ===== sv/chull_ram.sv =====
// ----------------------------------------------------------------------------
// chull_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chull_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/convex_hull_2d.sv =====
// ----------------------------------------------------------------------------
// convex_hull_2d: Graham scan convex hull of a loaded 2D point set
// Loads points one beat at a time; on the beat marked last it finds the
// pivot, sorts the rest by angle and scans, then streams the hull vertices.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+---------------------
//  point in | point_x_i, point_y_i, last_point_i         | start && !busy
//  vertex   | vertex_x_o, vertex_y_o, vertex_count_o,    | vertex_valid_o strobe,
//           | last_vertex_o                              | one cycle, no stall
//
//  A point that is not last is stored while there is room. A last point
//  starts the hull: a pass to find the pivot, a pass to seed the order
//  memory, then per insertion a first compare, a compare for each further
//  shift and a write to place it (O(n^2) compares worst case). The two seed
//  stack entries follow, then the scan steps, each pop adding a compare, and
//  each vertex out reads the stack, then the point store. All of it runs on
//  one shared 17x17 multiplier and single-port reads of the three memories.
//  Reset clears the sequencer and counters; memories hold garbage until
//  written and are never read before that. The receiver cannot stall.
//
module convex_hull_2d (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [chull_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [chull_pkg::COORD_BITS-1:0] point_y_i,
  input  logic                                 last_point_i,
  output logic                                 vertex_valid_o,
  output logic signed [chull_pkg::COORD_BITS-1:0] vertex_x_o,
  output logic signed [chull_pkg::COORD_BITS-1:0] vertex_y_o,
  output logic        [chull_pkg::CNT_W-1:0]      vertex_count_o,
  output logic                                 last_vertex_o
);

  import chull_pkg::*;

  // sequencer codes
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_PIV_RD   = 5'd1;
  localparam logic [ST_W-1:0] S_PIV_CMP  = 5'd2;
  localparam logic [ST_W-1:0] S_ORD      = 5'd3;
  localparam logic [ST_W-1:0] S_SORT_RV  = 5'd4;
  localparam logic [ST_W-1:0] S_SORT_RVP = 5'd5;
  localparam logic [ST_W-1:0] S_SORT_VC  = 5'd6;
  localparam logic [ST_W-1:0] S_SORT_RB  = 5'd7;
  localparam logic [ST_W-1:0] S_SORT_RBP = 5'd8;
  localparam logic [ST_W-1:0] S_SORT_BC  = 5'd9;
  localparam logic [ST_W-1:0] S_MUL1     = 5'd10;
  localparam logic [ST_W-1:0] S_MUL2     = 5'd11;
  localparam logic [ST_W-1:0] S_EVAL     = 5'd12;
  localparam logic [ST_W-1:0] S_SORT_PUT = 5'd13;
  localparam logic [ST_W-1:0] S_STK1     = 5'd14;
  localparam logic [ST_W-1:0] S_STK1P    = 5'd15;
  localparam logic [ST_W-1:0] S_STK1C    = 5'd16;
  localparam logic [ST_W-1:0] S_SCAN_RK  = 5'd17;
  localparam logic [ST_W-1:0] S_SCAN_RKP = 5'd18;
  localparam logic [ST_W-1:0] S_SCAN_LC  = 5'd19;
  localparam logic [ST_W-1:0] S_SCAN_OP  = 5'd20;
  localparam logic [ST_W-1:0] S_SCAN_POP = 5'd21;
  localparam logic [ST_W-1:0] S_SCAN_PPC = 5'd22;
  localparam logic [ST_W-1:0] S_OUT_RS   = 5'd23;
  localparam logic [ST_W-1:0] S_OUT_RP   = 5'd24;
  localparam logic [ST_W-1:0] S_OUT_EM   = 5'd25;

  localparam logic PH_SORT = 1'b0;
  localparam logic PH_SCAN = 1'b1;

  logic [ST_W-1:0] state_q, state_d;

  // control counters
  logic [CNT_W-1:0] cnt_q, n_q, i_q, j_q, k_q, d_q;
  logic             phase_q;

  // payload registers
  logic [IDX_W-1:0] piv_q, v_idx_q, b_idx_q, c_idx_q, t1_idx_q;
  coord_t           px_q, py_q, t1x_q, t1y_q, t2x_q, t2y_q, cx_q, cy_q;
  diff_t            vax_q, vay_q, op_a_q, op_b_q, op_c_q, op_d_q;
  norm_t            vna_q, bna_q;
  logic signed [PROD_W-1:0] p1_q, p2_q, mul_p;

  // memory ports
  logic             pt_we, ord_we, stk_we;
  logic [IDX_W-1:0] pt_waddr, pt_raddr, ord_waddr, ord_raddr, stk_waddr, stk_raddr;
  logic [PT_W-1:0]  pt_wdata, pt_rdata;
  logic [IDX_W-1:0] ord_wdata, ord_rdata, stk_wdata, stk_rdata;

  chull_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  chull_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  chull_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // point read back from the store, and its offset from the pivot
  coord_t           rd_x, rd_y;
  diff_t            rd_dx, rd_dy, rd_dy_adj;
  norm_t            rd_norm;
  logic [CNT_W-1:0] last_idx, stk_top_rd;
  logic             room, take, ahead, turn_gt, turn_eq;

  assign rd_x      = pt_rdata[COORD_BITS-1:0];
  assign rd_y      = pt_rdata[PT_W-1:COORD_BITS];
  assign rd_dx     = coord_diff(rd_x, px_q);
  assign rd_dy     = coord_diff(rd_y, py_q);
  // a point on top of the pivot sorts as if straight above it
  assign rd_dy_adj = (rd_dx == '0 && rd_dy == '0) ? diff_t'(1) : rd_dy;
  assign rd_norm   = diff_mag(rd_dx) + diff_mag(rd_dy);

  assign last_idx   = n_q - CNT_W'(1);
  assign stk_top_rd = d_q - CNT_W'(1) - i_q;
  assign room       = cnt_q < CNT_W'(MAX_POINTS);

  // lowest y wins, then lowest x; later duplicates replace earlier ones
  assign take = (i_q == '0) || (rd_y < py_q) || (rd_y == py_q && rd_x <= px_q);

  // shared multiplier
  always_comb begin
    if (state_q == S_MUL2) begin
      mul_p = op_c_q * op_d_q;
    end else begin
      mul_p = op_a_q * op_b_q;
    end
  end

  assign turn_gt = p1_q > p2_q;
  assign turn_eq = p1_q == p2_q;
  assign ahead   = turn_gt || (turn_eq && vna_q < bna_q);

  // sequencer and memory control
  always_comb begin
    state_d   = state_q;
    pt_we     = 1'b0;
    pt_waddr  = cnt_q[IDX_W-1:0];
    pt_wdata  = {point_y_i, point_x_i};
    pt_raddr  = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    ord_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          pt_we = room;
          if (last_point_i) begin
            state_d = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        pt_raddr = i_q[IDX_W-1:0];
        state_d  = S_PIV_CMP;
      end
      S_PIV_CMP: begin
        if (i_q == last_idx) begin
          state_d = (n_q == CNT_W'(1)) ? S_STK1 : S_ORD;
        end else begin
          state_d = S_PIV_RD;
        end
      end
      S_ORD: begin
        // pivot slot takes the last point; the others keep their place
        ord_we    = 1'b1;
        ord_waddr = i_q[IDX_W-1:0];
        ord_wdata = (i_q[IDX_W-1:0] == piv_q) ? last_idx[IDX_W-1:0] : i_q[IDX_W-1:0];
        if (i_q == n_q - CNT_W'(2)) begin
          state_d = (n_q == CNT_W'(2)) ? S_STK1 : S_SORT_RV;
        end
      end
      S_SORT_RV: begin
        ord_raddr = i_q[IDX_W-1:0];
        state_d   = S_SORT_RVP;
      end
      S_SORT_RVP: begin
        pt_raddr = ord_rdata;
        state_d  = S_SORT_VC;
      end
      S_SORT_VC: begin
        state_d = S_SORT_RB;
      end
      S_SORT_RB: begin
        ord_raddr = j_q[IDX_W-1:0] - IDX_W'(1);
        state_d   = S_SORT_RBP;
      end
      S_SORT_RBP: begin
        pt_raddr = ord_rdata;
        state_d  = S_SORT_BC;
      end
      S_SORT_BC: begin
        state_d = S_MUL1;
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (phase_q == PH_SORT) begin
          if (ahead) begin
            // shift the compared entry up one slot
            ord_we    = 1'b1;
            ord_waddr = j_q[IDX_W-1:0];
            ord_wdata = b_idx_q;
            state_d   = (j_q == CNT_W'(1)) ? S_SORT_PUT : S_SORT_RB;
          end else begin
            state_d = S_SORT_PUT;
          end
        end else begin
          if (turn_gt) begin
            stk_we    = 1'b1;
            stk_waddr = d_q[IDX_W-1:0];
            stk_wdata = c_idx_q;
            state_d   = (k_q + CNT_W'(1) == last_idx) ? S_OUT_RS : S_SCAN_RK;
          end else if (turn_eq || d_q == CNT_W'(2)) begin
            // collinear, or clockwise on a two-entry stack: replace the top
            stk_we    = 1'b1;
            stk_waddr = d_q[IDX_W-1:0] - IDX_W'(1);
            stk_wdata = c_idx_q;
            state_d   = (k_q + CNT_W'(1) == last_idx) ? S_OUT_RS : S_SCAN_RK;
          end else begin
            // pop, and fetch the new second entry
            stk_raddr = d_q[IDX_W-1:0] - IDX_W'(3);
            state_d   = S_SCAN_POP;
          end
        end
      end
      S_SORT_PUT: begin
        ord_we    = 1'b1;
        ord_waddr = j_q[IDX_W-1:0];
        ord_wdata = v_idx_q;
        state_d   = (i_q + CNT_W'(1) == last_idx) ? S_STK1 : S_SORT_RV;
      end
      S_STK1: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = piv_q;
        ord_raddr = '0;
        state_d   = (n_q == CNT_W'(1)) ? S_OUT_RS : S_STK1P;
      end
      S_STK1P: begin
        pt_raddr = ord_rdata;
        state_d  = S_STK1C;
      end
      S_STK1C: begin
        stk_we    = 1'b1;
        stk_waddr = IDX_W'(1);
        stk_wdata = t1_idx_q;
        state_d   = (n_q == CNT_W'(2)) ? S_OUT_RS : S_SCAN_RK;
      end
      S_SCAN_RK: begin
        ord_raddr = k_q[IDX_W-1:0];
        state_d   = S_SCAN_RKP;
      end
      S_SCAN_RKP: begin
        pt_raddr = ord_rdata;
        state_d  = S_SCAN_LC;
      end
      S_SCAN_LC: begin
        state_d = S_SCAN_OP;
      end
      S_SCAN_OP: begin
        state_d = S_MUL1;
      end
      S_SCAN_POP: begin
        pt_raddr = stk_rdata;
        state_d  = S_SCAN_PPC;
      end
      S_SCAN_PPC: begin
        state_d = S_SCAN_OP;
      end
      S_OUT_RS: begin
        stk_raddr = stk_top_rd[IDX_W-1:0];
        state_d   = S_OUT_RP;
      end
      S_OUT_RP: begin
        pt_raddr = stk_rdata;
        state_d  = S_OUT_EM;
      end
      S_OUT_EM: begin
        state_d = (i_q == d_q - CNT_W'(1)) ? S_IDLE : S_OUT_RS;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      d_q     <= '0;
      phase_q <= PH_SORT;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            if (last_point_i) begin
              n_q   <= room ? cnt_q + CNT_W'(1) : cnt_q;
              cnt_q <= '0;
              i_q   <= '0;
            end else if (room) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        S_PIV_CMP: begin
          i_q <= (i_q == last_idx) ? '0 : i_q + CNT_W'(1);
        end
        S_ORD: begin
          i_q <= (i_q == n_q - CNT_W'(2)) ? CNT_W'(1) : i_q + CNT_W'(1);
        end
        S_SORT_VC: begin
          j_q <= i_q;
        end
        S_SORT_BC: begin
          phase_q <= PH_SORT;
        end
        S_SCAN_OP: begin
          phase_q <= PH_SCAN;
        end
        S_EVAL: begin
          if (phase_q == PH_SORT) begin
            if (ahead) begin
              j_q <= j_q - CNT_W'(1);
            end
          end else if (turn_gt) begin
            d_q <= d_q + CNT_W'(1);
            k_q <= k_q + CNT_W'(1);
            i_q <= '0;
          end else if (turn_eq || d_q == CNT_W'(2)) begin
            k_q <= k_q + CNT_W'(1);
            i_q <= '0;
          end else begin
            d_q <= d_q - CNT_W'(1);
          end
        end
        S_SORT_PUT: begin
          i_q <= i_q + CNT_W'(1);
        end
        S_STK1: begin
          d_q <= CNT_W'(1);
          i_q <= '0;
        end
        S_STK1C: begin
          d_q <= CNT_W'(2);
          k_q <= CNT_W'(1);
          i_q <= '0;
        end
        S_OUT_EM: begin
          i_q <= i_q + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_PIV_CMP: begin
        if (take) begin
          px_q  <= rd_x;
          py_q  <= rd_y;
          piv_q <= i_q[IDX_W-1:0];
        end
      end
      S_SORT_RVP: begin
        v_idx_q <= ord_rdata;
      end
      S_SORT_VC: begin
        vax_q <= rd_dx;
        vay_q <= rd_dy_adj;
        vna_q <= rd_norm;
      end
      S_SORT_RBP: begin
        b_idx_q <= ord_rdata;
      end
      S_SORT_BC: begin
        op_a_q <= vax_q;
        op_b_q <= rd_dy_adj;
        op_c_q <= vay_q;
        op_d_q <= rd_dx;
        bna_q  <= rd_norm;
      end
      S_MUL1: begin
        p1_q <= mul_p;
      end
      S_MUL2: begin
        p2_q <= mul_p;
      end
      S_STK1P: begin
        t1_idx_q <= ord_rdata;
      end
      S_STK1C: begin
        t1x_q <= rd_x;
        t1y_q <= rd_y;
        t2x_q <= px_q;
        t2y_q <= py_q;
      end
      S_SCAN_RKP: begin
        c_idx_q <= ord_rdata;
      end
      S_SCAN_LC: begin
        cx_q <= rd_x;
        cy_q <= rd_y;
      end
      S_SCAN_OP: begin
        op_a_q <= coord_diff(t1x_q, t2x_q);
        op_b_q <= coord_diff(cy_q, t2y_q);
        op_c_q <= coord_diff(t1y_q, t2y_q);
        op_d_q <= coord_diff(cx_q, t2x_q);
      end
      S_EVAL: begin
        if (phase_q == PH_SCAN) begin
          if (turn_gt) begin
            t2x_q    <= t1x_q;
            t2y_q    <= t1y_q;
            t1x_q    <= cx_q;
            t1y_q    <= cy_q;
            t1_idx_q <= c_idx_q;
          end else if (turn_eq || d_q == CNT_W'(2)) begin
            t1x_q    <= cx_q;
            t1y_q    <= cy_q;
            t1_idx_q <= c_idx_q;
          end else begin
            t1x_q <= t2x_q;
            t1y_q <= t2y_q;
          end
        end
      end
      S_SCAN_PPC: begin
        t2x_q <= rd_x;
        t2y_q <= rd_y;
      end
      default: begin
      end
    endcase
  end

  // outputs
  assign busy           = state_q != S_IDLE;
  assign vertex_valid_o = state_q == S_OUT_EM;
  assign vertex_x_o     = rd_x;
  assign vertex_y_o     = rd_y;
  assign vertex_count_o = d_q;
  assign last_vertex_o  = vertex_valid_o && (i_q == d_q - CNT_W'(1));

endmodule
